[sv/key_length_value_record_parser_unit_macros.svh]
// Assertion macros used by the record parser core.
`ifndef KEY_LENGTH_VALUE_RECORD_PARSER_UNIT_MACROS_SVH
`define KEY_LENGTH_VALUE_RECORD_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define KLVP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("klvp assertion failed");

// Checks a property on every clock edge, reset included.
`define KLVP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("klvp assertion failed");

`else

`define KLVP_ASSERT(label, clk, rst, prop)

`define KLVP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[sv/klvp_pkg.sv]
package klvp_pkg;

  // Longest key, terminator included, before the parser flags an error.
  localparam int MAX_KEY_BYTES = 32;
  // The key counter must hold one past the limit.
  localparam int KEY_COUNT_W = $clog2(MAX_KEY_BYTES + 2);

  // Final status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_KEY_LONG  = 3'd1;
  localparam logic [2:0] ST_KEY_EMPTY = 3'd2;
  localparam logic [2:0] ST_LEN_ZERO  = 3'd3;
  localparam logic [2:0] ST_NOT_DONE  = 3'd4;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic        record_valid;
    logic [4:0]  key_length;
    logic [31:0] value_address;
    logic [15:0] value_length;
    logic        stream_done;
    logic [2:0]  final_status;
  } out_item_t;

  // Handoff from the input register to the parser core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

[sv/klvp_in_stage.sv]
module klvp_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  klvp_pkg::in_item_t in_item,
  input  logic              advance,
  output klvp_pkg::stage_t  stage
);
  import klvp_pkg::*;

  logic     held;
  in_item_t item;

  // The register takes a new beat when empty or when its beat moves on.
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign stage.valid = held;
  assign stage.item  = item;

endmodule

[sv/klvp_core.sv]
`include "key_length_value_record_parser_unit_macros.svh"

module klvp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  klvp_pkg::stage_t   stage,
  input  logic               advance,
  output logic               emit,
  output klvp_pkg::out_item_t result
);
  import klvp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_KEY,
    PH_LEN,
    PH_VALUE
  } phase_t;

  logic [31:0]            start_address;
  phase_t                 phase, phase_next;
  logic [KEY_COUNT_W-1:0] key_count, key_count_next;
  logic [15:0]            length_acc, length_acc_next;
  logic                   length_seen, length_seen_next;
  logic [15:0]            value_remaining, value_remaining_next;
  logic [31:0]            value_start, value_start_next;
  logic [31:0]            byte_position, byte_position_next;
  logic [2:0]             error_code, error_code_next;

  logic [7:0]  data;
  logic        last;
  logic [31:0] addr;
  logic [15:0] value_left;
  logic        done_rec;
  logic [2:0]  status;
  logic        error_held;
  logic        rec_emit;

  assign data = stage.item.data_byte;
  assign last = stage.item.last_byte;
  assign addr = start_address + byte_position;

  // Start address register: the user writes it only while the parser is idle; unchecked.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
    end else if (cfg_valid) begin
      start_address <= cfg_data;
    end
  end

  // Per-byte state update and result assembly.
  always_comb begin
    phase_next           = phase;
    key_count_next       = key_count;
    length_acc_next      = length_acc;
    length_seen_next     = length_seen;
    value_remaining_next = value_remaining;
    value_start_next     = value_start;
    error_code_next      = error_code;
    byte_position_next   = byte_position + 32'd1;
    value_left           = value_remaining - {15'd0, (value_remaining != 16'd0)};
    done_rec             = 1'b0;
    status               = ST_OK;
    result               = '0;

    if (error_code == ST_OK) begin
      unique case (phase)
        PH_IDLE, PH_KEY: begin
          // Zero bytes between records are padding.
          if (!(phase == PH_IDLE && data == 8'd0)) begin
            phase_next     = PH_KEY;
            key_count_next = key_count + KEY_COUNT_W'(1);
            if (key_count_next >= KEY_COUNT_W'(MAX_KEY_BYTES) && data != 8'd0) begin
              error_code_next = ST_KEY_LONG;
            end else if (data == 8'd0) begin
              if (key_count_next <= KEY_COUNT_W'(1)) begin
                error_code_next = ST_KEY_EMPTY;
              end else begin
                phase_next = PH_LEN;
              end
            end
          end
        end
        PH_LEN: begin
          // Length arrives low byte first.
          if (!length_seen) begin
            length_acc_next  = {8'd0, data};
            length_seen_next = 1'b1;
          end else begin
            length_acc_next = {data, length_acc[7:0]};
            if (length_acc_next == 16'd0) begin
              error_code_next = ST_LEN_ZERO;
            end else begin
              phase_next           = PH_VALUE;
              value_remaining_next = length_acc_next;
              value_start_next     = addr + 32'd1;
            end
          end
        end
        PH_VALUE: begin
          value_remaining_next = value_left;
          if (value_left == 16'd0) begin
            done_rec             = 1'b1;
            result.record_valid  = 1'b1;
            result.key_length    = 5'(key_count - KEY_COUNT_W'(1));
            result.value_address = value_start;
            result.value_length  = length_acc;
            phase_next           = PH_IDLE;
            key_count_next       = '0;
            length_acc_next      = '0;
            length_seen_next     = 1'b0;
            value_start_next     = '0;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // The last beat reports the status and clears the parser.
    if (last) begin
      status = error_code_next;
      if (status == ST_OK && phase_next != PH_IDLE) begin
        status = ST_NOT_DONE;
      end
      result.stream_done   = 1'b1;
      result.final_status  = status;
      phase_next           = PH_IDLE;
      key_count_next       = '0;
      length_acc_next      = '0;
      length_seen_next     = 1'b0;
      value_remaining_next = '0;
      value_start_next     = '0;
      byte_position_next   = '0;
      error_code_next      = ST_OK;
    end

    emit = stage.valid && (done_rec || last);
  end

  // Parser state moves with each beat that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      key_count       <= '0;
      length_acc      <= '0;
      length_seen     <= 1'b0;
      value_remaining <= '0;
      value_start     <= '0;
      byte_position   <= '0;
      error_code      <= ST_OK;
    end else if (advance) begin
      phase           <= phase_next;
      key_count       <= key_count_next;
      length_acc      <= length_acc_next;
      length_seen     <= length_seen_next;
      value_remaining <= value_remaining_next;
      value_start     <= value_start_next;
      byte_position   <= byte_position_next;
      error_code      <= error_code_next;
    end
  end

  // Conditions watched by the checks below.
  assign error_held = (error_code != ST_OK) && !(advance && last);
  assign rec_emit   = emit && result.record_valid;

  // An error sticks until the last beat of the image.
  `KLVP_ASSERT(a_error_sticks, clk, rst, error_held |=> $stable(error_code))
  // A record in its value phase always has bytes left to come.
  `KLVP_ASSERT(a_value_left, clk, rst, (phase == PH_VALUE) |-> (value_remaining != 16'd0))
  // The key counter never passes the key limit.
  `KLVP_ASSERT(a_key_bound, clk, rst, key_count <= KEY_COUNT_W'(MAX_KEY_BYTES))
  // A reported record never has an empty value.
  `KLVP_ASSERT(a_rec_len, clk, rst, rec_emit |-> (result.value_length != 16'd0))

endmodule

[sv/klvp_out_stage.sv]
module klvp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  klvp_pkg::out_item_t result,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output klvp_pkg::out_item_t out_item
);
  import klvp_pkg::*;

  out_item_t held;

  // The slot can take a result when empty or when its beat leaves now.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign out_item = held;

endmodule

[sv/key_length_value_record_parser_unit.sv]
// Parses a stored settings image of key / 16-bit length / value records, one
// byte per beat, and reports each completed record (key length, absolute value
// address from the start address register, value length) plus a final status
// on the beat marked last. It takes one byte every clock cycle: each byte is
// held in an input register, the parser state updates as it leaves, and any
// result lands in the output register as the byte leaves the input register.
// The only stall comes from the output side: a byte that yields a result waits
// while the output register still holds an untaken result. Write the start
// address only while no byte is in flight.
module key_length_value_record_parser_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  klvp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output klvp_pkg::out_item_t out_item
);
  import klvp_pkg::*;

  stage_t    stage;
  out_item_t result;
  logic      emit;
  logic      free;
  logic      advance;

  assign cfg_ready = 1'b1;

  // A held byte moves on unless its result has no room.
  assign advance = stage.valid && (!emit || free);

  klvp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  klvp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .advance   (advance),
    .emit      (emit),
    .result    (result)
  );

  klvp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
